### sv/vog_pkg.sv
// Package with shared constants, register indexes and reset values of the voxel occupancy grid.
`default_nettype none

package vog_pkg;

    // Width of a coordinate and of a configuration register, Q16.16.
    localparam int COORD_W = 32;

    // Default grid dimensions in voxels.
    localparam int GRID_X_DEF = 64;
    localparam int GRID_Y_DEF = 64;
    localparam int GRID_Z_DEF = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RES  = 3'd6;

    // Register values after reset.
    localparam logic signed [COORD_W-1:0] ORIGIN_RST  = 32'sd0;
    localparam logic signed [COORD_W-1:0] LIMIT_X_RST = 32'sd419430;
    localparam logic signed [COORD_W-1:0] LIMIT_Y_RST = 32'sd419430;
    localparam logic signed [COORD_W-1:0] LIMIT_Z_RST = 32'sd104858;
    localparam logic [COORD_W-1:0]        INV_RES_RST = 32'd655360;

    // Item commands.
    localparam logic CMD_MARK  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

### sv/vog_if.sv
// Channel interfaces of the voxel occupancy grid: items, results and configuration writes.
`default_nettype none

interface vog_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic signed [vog_pkg::COORD_W-1:0]   coord_x_in;
    logic signed [vog_pkg::COORD_W-1:0]   coord_y_in;
    logic signed [vog_pkg::COORD_W-1:0]   coord_z_in;

    modport source (output valid, cmd, coord_x_in, coord_y_in, coord_z_in, input ready);
    modport sink   (input valid, cmd, coord_x_in, coord_y_in, coord_z_in, output ready);
endinterface

interface vog_result_if;
    logic valid;
    logic ready;
    logic is_free;

    modport source (output valid, is_free, input ready);
    modport sink   (input valid, is_free, output ready);
endinterface

interface vog_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vog_pkg::CFG_IDX_W-1:0]     index;
    logic [vog_pkg::COORD_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/voxel_occupancy_grid.sv
// Top level of the voxel occupancy grid: a one-bit-per-voxel store with mark and query commands.
//
// Usage. Items arrive on the item channel as a transaction carrying cmd and a point
// (coord_x_in, coord_y_in, coord_z_in, signed Q16.16). A mark (cmd 0) sets the bit of the voxel
// holding the point when the point lies inside [origin, limit) and inside the grid; it gives no
// result. A query (cmd 1) clamps the voxel index into the grid and returns one transaction on the
// result channel whose is_free bit is 1 when that voxel was never marked.
// Configuration writes arrive on cfg (index 0..6: origin x/y/z, limit x/y/z, inverse resolution)
// and are always taken; they are meant to be written while no item is in flight.
// Timing. One item is worked on at a time. The three axes share one 32x32 multiplier, one axis
// per cycle, followed by an address stage and one access of the occupancy memory. A mark writes
// its voxel in the memory stage; a query reads its bit there and its result is then loaded into
// the output register. The block takes a new item only after the last one has left the controller,
// so the shared multiplier and the single memory port bound its throughput.
// Stalls. The result sits in an output register; the next item is accepted while it waits.
// A second query waits in its final stage until the earlier result has been taken.
// Reset. After rst_n is released a clearing pass writes zero to every voxel (65536 at default size),
// one per cycle; item.ready stays low during the pass.
`default_nettype none

module voxel_occupancy_grid #(
    parameter int GRID_X = vog_pkg::GRID_X_DEF,
    parameter int GRID_Y = vog_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vog_pkg::GRID_Z_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    vog_item_if.sink        item,
    vog_result_if.source    result,
    vog_cfg_if.sink         cfg
);

    localparam int VOXELS = GRID_X * GRID_Y * GRID_Z;
    localparam int YZ     = GRID_Y * GRID_Z;
    localparam int AW     = (VOXELS > 1) ? $clog2(VOXELS) : 1;
    localparam int XW     = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW     = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW     = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int CW     = vog_pkg::COORD_W;

    // Controller states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_AXIS = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_MEM  = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    // Configuration registers.
    logic signed [CW-1:0] origin_reg [3];
    logic signed [CW-1:0] limit_reg  [3];
    logic [CW-1:0]        inv_res_reg;

    // Controller and clearing pass.
    logic [2:0]    state_reg, state_next;
    logic [1:0]    ax_cnt_reg, ax_cnt_next;
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Item payload and per-item working values.
    logic                 cmd_reg;
    logic signed [CW-1:0] coord_reg [3];
    logic                 outside_reg, outside_next;
    logic [CW-1:0]        prod_hi_reg;
    logic [XW-1:0]        ix_reg;
    logic [YW-1:0]        iy_reg;
    logic [ZW-1:0]        iz_reg;
    logic [AW-1:0]        addr_reg;

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic is_free_reg;

    // Occupancy memory.
    logic          occ_mem [VOXELS];
    logic          rd_bit_reg;
    logic          mem_we, mem_re, mem_wdata;
    logic [AW-1:0] mem_waddr;

    logic item_acc;
    logic load_out;

    assign item.ready    = (state_reg == ST_IDLE) && !clearing_reg;
    assign item_acc      = item.valid && item.ready;
    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.is_free = is_free_reg;

    // ------------------------------------------------------------------
    // Axis datapath: the multiplier handles axis ax_cnt while the product
    // of the previous axis is clamped and checked against the grid.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] sel_coord, sel_origin, sel_limit;
    logic signed [CW:0]   diff;
    logic [CW-1:0]        mul_op;
    logic [2*CW-1:0]      product;
    logic [CW-1:0]        grid_sz;
    logic                 over_grid;
    logic [CW-1:0]        clamped;

    always_comb
    begin
        case (ax_cnt_reg)
            2'd0:
            begin
                sel_coord  = coord_reg[0];
                sel_origin = origin_reg[0];
                sel_limit  = limit_reg[0];
                grid_sz    = CW'(GRID_Z);
            end
            2'd1:
            begin
                sel_coord  = coord_reg[1];
                sel_origin = origin_reg[1];
                sel_limit  = limit_reg[1];
                grid_sz    = CW'(GRID_X);
            end
            2'd2:
            begin
                sel_coord  = coord_reg[2];
                sel_origin = origin_reg[2];
                sel_limit  = limit_reg[2];
                grid_sz    = CW'(GRID_Y);
            end
            default:
            begin
                sel_coord  = coord_reg[2];
                sel_origin = origin_reg[2];
                sel_limit  = limit_reg[2];
                grid_sz    = CW'(GRID_Z);
            end
        endcase
        // The offset of a point at or above the origin fits in 32 unsigned bits.
        diff    = (CW+1)'(sel_coord) - (CW+1)'(sel_origin);
        mul_op  = diff[CW] ? '0 : diff[CW-1:0];
        product = (2*CW)'(mul_op) * (2*CW)'(inv_res_reg);
        // grid_sz belongs to the axis whose product sits in prod_hi_reg.
        over_grid = (prod_hi_reg >= grid_sz);
        clamped   = over_grid ? (grid_sz - CW'(1)) : prod_hi_reg;
    end

    always_comb
    begin
        outside_next = outside_reg;
        if (item_acc)
        begin
            outside_next = 1'b0;
        end
        else if (state_reg == ST_AXIS)
        begin
            if ((ax_cnt_reg != 2'd3) && (diff[CW] || (sel_coord >= sel_limit)))
            begin
                outside_next = 1'b1;
            end
            if ((ax_cnt_reg != 2'd0) && over_grid)
            begin
                outside_next = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Controller.
    // ------------------------------------------------------------------
    assign load_out = (state_reg == ST_RESP) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next  = state_reg;
        ax_cnt_next = ax_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    state_next  = ST_AXIS;
                    ax_cnt_next = 2'd0;
                end
            end
            ST_AXIS:
            begin
                ax_cnt_next = ax_cnt_reg + 2'd1;
                if (ax_cnt_reg == 2'd3)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_MEM;
            end
            ST_MEM:
            begin
                state_next = (cmd_reg == vog_pkg::CMD_QUERY) ? ST_RESP : ST_IDLE;
            end
            ST_RESP:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ax_cnt_reg    <= 2'd0;
            outside_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            origin_reg[0] <= vog_pkg::ORIGIN_RST;
            origin_reg[1] <= vog_pkg::ORIGIN_RST;
            origin_reg[2] <= vog_pkg::ORIGIN_RST;
            limit_reg[0]  <= vog_pkg::LIMIT_X_RST;
            limit_reg[1]  <= vog_pkg::LIMIT_Y_RST;
            limit_reg[2]  <= vog_pkg::LIMIT_Z_RST;
            inv_res_reg   <= vog_pkg::INV_RES_RST;
        end
        else
        begin
            state_reg     <= state_next;
            ax_cnt_reg    <= ax_cnt_next;
            outside_reg   <= outside_next;
            out_valid_reg <= out_valid_next;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(VOXELS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    vog_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg.data;
                    vog_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg.data;
                    vog_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg.data;
                    vog_pkg::REG_LIMIT_X:  limit_reg[0]  <= cfg.data;
                    vog_pkg::REG_LIMIT_Y:  limit_reg[1]  <= cfg.data;
                    vog_pkg::REG_LIMIT_Z:  limit_reg[2]  <= cfg.data;
                    vog_pkg::REG_INV_RES:  inv_res_reg   <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            cmd_reg      <= item.cmd;
            coord_reg[0] <= item.coord_x_in;
            coord_reg[1] <= item.coord_y_in;
            coord_reg[2] <= item.coord_z_in;
        end
        if (state_reg == ST_AXIS)
        begin
            prod_hi_reg <= product[2*CW-1:CW];
            case (ax_cnt_reg)
                2'd1: ix_reg <= XW'(clamped);
                2'd2: iy_reg <= YW'(clamped);
                2'd3: iz_reg <= ZW'(clamped);
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= (AW'(ix_reg) * AW'(YZ)) + (AW'(iy_reg) * AW'(GRID_Z)) + AW'(iz_reg);
        end
        if (load_out)
        begin
            is_free_reg <= !rd_bit_reg;
        end
    end

    // ------------------------------------------------------------------
    // Occupancy memory: one write port shared by the clearing pass and
    // marks, one registered read port for queries. A mark writes in the
    // same stage where a later query reads, so program order holds.
    // ------------------------------------------------------------------
    assign mem_we    = clearing_reg ||
                       ((state_reg == ST_MEM) && (cmd_reg == vog_pkg::CMD_MARK) && !outside_reg);
    assign mem_waddr = clearing_reg ? clr_cnt_reg : addr_reg;
    assign mem_wdata = !clearing_reg;
    assign mem_re    = (state_reg == ST_MEM) && (cmd_reg == vog_pkg::CMD_QUERY);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_bit_reg <= occ_mem[addr_reg];
        end
    end

endmodule

`default_nettype wire

### sv/vog_checker.sv
// Port checker of the voxel occupancy grid and its bind to the top level.
`default_nettype none

module vog_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic is_free,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    // A result waiting for the receiver keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(is_free)))
        else $error("result changed while stalled");

    // Only one item is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while another is in flight");

    // A result never appears right after an item was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result too early after acceptance");

    // Configuration writes are never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind voxel_occupancy_grid vog_checker u_vog_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .is_free   (result.is_free),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

`default_nettype wire

### verif/tb.sv
// Self-checking testbench of the voxel occupancy grid: mark and query traffic against a predictor.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // After the last expected result, a mark may still be on its way to the
    // occupancy memory, so the idle wait leaves some margin.
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEMS_PER_MAP = 245;
    localparam int MARK_MEMORY = 64;
    localparam int VOXELS = vog_pkg::GRID_X_DEF * vog_pkg::GRID_Y_DEF * vog_pkg::GRID_Z_DEF;
    localparam longint Q_MAX_L = 64'sd2147483647;
    localparam longint Q_MIN_L = -64'sd2147483648;
    localparam longint ONE_M = 64'sd65536;

    typedef logic [2:0][vog_pkg::COORD_W-1:0] point_t;

    typedef struct packed {
        logic   is_free;
        point_t where;
    } free_expect_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Percentage of cycles in which the item sender holds back and the
    // result receiver drops ready.
    int send_idle_pct = 35;
    int recv_idle_pct = 46;
    int mismatches = 0;

    // Predicted copy of the map registers and of the occupancy store.
    logic signed [vog_pkg::COORD_W-1:0] map_origin [3] =
        '{vog_pkg::ORIGIN_RST, vog_pkg::ORIGIN_RST, vog_pkg::ORIGIN_RST};
    logic signed [vog_pkg::COORD_W-1:0] map_limit [3] =
        '{vog_pkg::LIMIT_X_RST, vog_pkg::LIMIT_Y_RST, vog_pkg::LIMIT_Z_RST};
    logic [vog_pkg::COORD_W-1:0]        map_inv_res = vog_pkg::INV_RES_RST;
    bit                                 occupied [VOXELS];

    // Expected is_free answers, oldest first, and points that really got marked.
    free_expect_t free_expected [$];
    point_t       marked_points [$];

    vog_item_if   item_ch ();
    vog_result_if result_ch ();
    vog_cfg_if    cfg_ch ();

    voxel_occupancy_grid dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #4 clk = ~clk;

    // The receiver drops ready at random; with recv_idle_pct at zero it is
    // always ready.
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < 50)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic int grid_size(input int axis);
        if (axis == 0)
        begin
            return vog_pkg::GRID_X_DEF;
        end
        if (axis == 1)
        begin
            return vog_pkg::GRID_Y_DEF;
        end
        return vog_pkg::GRID_Z_DEF;
    endfunction

    function automatic logic [vog_pkg::COORD_W-1:0] sat32(input longint v);
        if (v > Q_MAX_L)
        begin
            return Q_MAX_L[vog_pkg::COORD_W-1:0];
        end
        if (v < Q_MIN_L)
        begin
            return Q_MIN_L[vog_pkg::COORD_W-1:0];
        end
        return v[vog_pkg::COORD_W-1:0];
    endfunction

    // Offset times voxels per metre is exact in Q32.32; the integer part is
    // the voxel index, truncated. Zero or negative offsets give index 0.
    function automatic logic [63:0] voxel_index(input longint offset);
        logic [63:0] mag;
        logic [63:0] rate;
        if (offset <= 0)
        begin
            return 64'd0;
        end
        mag = offset;
        rate = {32'd0, map_inv_res};
        return (mag * rate) >> 32;
    endfunction

    function automatic logic [63:0] clamp_index(input logic [63:0] idx, input int size);
        return (idx >= size) ? 64'(size - 1) : idx;
    endfunction

    function automatic int unsigned voxel_addr(input logic [63:0] ix, input logic [63:0] iy,
                                               input logic [63:0] iz);
        logic [63:0] a;
        a = ix * (vog_pkg::GRID_Y_DEF * vog_pkg::GRID_Z_DEF) + iy * vog_pkg::GRID_Z_DEF + iz;
        return a[31:0];
    endfunction

    // Applies one accepted item to the predicted store. A mark inside the box
    // and inside the grid sets its voxel; a query leaves one expected answer.
    task automatic predict_item(input logic cmd, input point_t p);
        longint       c [3];
        longint       off [3];
        logic [63:0]  idx [3];
        bit           in_box;
        int unsigned  a;
        free_expect_t e;
        in_box = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            c[k] = longint'($signed(p[k]));
            off[k] = c[k] - longint'(map_origin[k]);
            if (off[k] < 0 || c[k] >= longint'(map_limit[k]))
            begin
                in_box = 1'b0;
            end
            idx[k] = voxel_index(off[k]);
        end
        if (cmd == vog_pkg::CMD_MARK)
        begin
            // A box that reaches past the grid must not wrap into other voxels.
            if (in_box && idx[0] < vog_pkg::GRID_X_DEF && idx[1] < vog_pkg::GRID_Y_DEF &&
                idx[2] < vog_pkg::GRID_Z_DEF)
            begin
                a = voxel_addr(idx[0], idx[1], idx[2]);
                occupied[a] = 1'b1;
                marked_points.push_back(p);
                if (marked_points.size() > MARK_MEMORY)
                begin
                    marked_points.delete(0);
                end
            end
        end
        else
        begin
            a = voxel_addr(clamp_index(idx[0], vog_pkg::GRID_X_DEF),
                           clamp_index(idx[1], vog_pkg::GRID_Y_DEF),
                           clamp_index(idx[2], vog_pkg::GRID_Z_DEF));
            e.is_free = !occupied[a];
            e.where = p;
            free_expected.push_back(e);
        end
    endtask

    // Sends one item. Valid stays high from one transaction to the next unless
    // the sender decides to idle first; the item is predicted at acceptance.
    task automatic send_item(input logic cmd, input logic [vog_pkg::COORD_W-1:0] x,
                             input logic [vog_pkg::COORD_W-1:0] y,
                             input logic [vog_pkg::COORD_W-1:0] z);
        point_t p;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= cmd;
        item_ch.coord_x_in <= x;
        item_ch.coord_y_in <= y;
        item_ch.coord_z_in <= z;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        predict_item(cmd, p);
    endtask

    // Holds the item channel idle until every query has been answered and any
    // trailing mark has had time to reach the store.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (free_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_register(input logic [vog_pkg::CFG_IDX_W-1:0] idx,
                                input logic [vog_pkg::COORD_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        case (idx)
            vog_pkg::REG_ORIGIN_X: map_origin[0] = value;
            vog_pkg::REG_ORIGIN_Y: map_origin[1] = value;
            vog_pkg::REG_ORIGIN_Z: map_origin[2] = value;
            vog_pkg::REG_LIMIT_X:  map_limit[0] = value;
            vog_pkg::REG_LIMIT_Y:  map_limit[1] = value;
            vog_pkg::REG_LIMIT_Z:  map_limit[2] = value;
            vog_pkg::REG_INV_RES:  map_inv_res = value;
            default: ;
        endcase
    endtask

    // Rewrites all seven map registers once the block is idle.
    task automatic apply_map_settings(input longint ox, input longint oy, input longint oz,
                                      input longint lx, input longint ly, input longint lz,
                                      input logic [vog_pkg::COORD_W-1:0] rate);
        wait_idle();
        put_register(vog_pkg::REG_ORIGIN_X, sat32(ox));
        put_register(vog_pkg::REG_ORIGIN_Y, sat32(oy));
        put_register(vog_pkg::REG_ORIGIN_Z, sat32(oz));
        put_register(vog_pkg::REG_LIMIT_X, sat32(lx));
        put_register(vog_pkg::REG_LIMIT_Y, sat32(ly));
        put_register(vog_pkg::REG_LIMIT_Z, sat32(lz));
        put_register(vog_pkg::REG_INV_RES, rate);
        cfg_ch.valid <= 1'b0;
    endtask

    // One coordinate: either a point around the grid (a voxel index from just
    // below zero to just past the end, with a random fraction), a box edge, a
    // range extreme, or any 32-bit value.
    function automatic logic [vog_pkg::COORD_W-1:0] pick_coord(input int axis,
                                                               input bit near_grid);
        longint base;
        longint v;
        longint frac;
        longint rate;
        int     raw;
        base = map_origin[axis];
        rate = map_inv_res;
        frac = $urandom;
        raw = $urandom;
        if (near_grid && rate != 0)
        begin
            v = base + ((longint'($urandom_range(grid_size(axis) + 3)) - 2) * (64'sd1 <<< 32)
                        + frac) / rate;
        end
        else if ($urandom_range(99) < 40)
        begin
            case ($urandom_range(5))
                0: v = base - 1;
                1: v = base;
                2: v = longint'(map_limit[axis]) - 1;
                3: v = map_limit[axis];
                4: v = Q_MIN_L;
                default: v = Q_MAX_L;
            endcase
        end
        else
        begin
            v = raw;
        end
        return sat32(v);
    endfunction

    // Most items land near the grid on all three axes so that marks take
    // effect; some revisit marked points so that queries find occupied voxels.
    task automatic send_random_item();
        point_t p;
        logic   cmd;
        int     mode;
        mode = $urandom_range(99);
        cmd = ($urandom_range(1) == 0) ? vog_pkg::CMD_MARK : vog_pkg::CMD_QUERY;
        if (mode < 20 && marked_points.size() > 0)
        begin
            p = marked_points[$urandom_range(marked_points.size() - 1)];
            cmd = ($urandom_range(3) == 0) ? vog_pkg::CMD_MARK : vog_pkg::CMD_QUERY;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                p[k] = pick_coord(k, mode < 80);
            end
        end
        send_item(cmd, p[0], p[1], p[2]);
    endtask

    // Reset map: 0.1 m voxels over 6.4 x 6.4 x 1.6 m. Covers a mark at the
    // origin, at the last voxel below the limit, at the limit, below the origin,
    // and queries that clamp below zero and past the end of the grid.
    task automatic test_mark_and_query_directed();
        apply_map_settings(vog_pkg::ORIGIN_RST, vog_pkg::ORIGIN_RST, vog_pkg::ORIGIN_RST,
                           vog_pkg::LIMIT_X_RST, vog_pkg::LIMIT_Y_RST, vog_pkg::LIMIT_Z_RST,
                           vog_pkg::INV_RES_RST);
        send_item(vog_pkg::CMD_QUERY, 32'sd0, 32'sd0, 32'sd0);
        send_item(vog_pkg::CMD_MARK, 32'sd0, 32'sd0, 32'sd0);
        send_item(vog_pkg::CMD_QUERY, 32'sd0, 32'sd0, 32'sd0);
        send_item(vog_pkg::CMD_QUERY, -32'sd65536, -32'sd1, 32'h8000_0000);
        send_item(vog_pkg::CMD_MARK, 32'sd419429, 32'sd419429, 32'sd104857);
        send_item(vog_pkg::CMD_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(vog_pkg::CMD_MARK, 32'sd419430, 32'sd0, 32'sd0);
        send_item(vog_pkg::CMD_QUERY, 32'sd419430, 32'sd0, 32'sd0);
        send_item(vog_pkg::CMD_MARK, 32'sd200000, 32'sd419430, 32'sd50000);
        send_item(vog_pkg::CMD_MARK, 32'sd200000, 32'sd100000, -32'sd1);
        send_item(vog_pkg::CMD_QUERY, 32'sd200000, 32'sd100000, 32'sd0);
        send_item(vog_pkg::CMD_MARK, 32'sd200000, 32'sd100000, 32'sd50000);
        send_item(vog_pkg::CMD_QUERY, 32'sd200000, 32'sd100000, 32'sd50000);
        send_item(vog_pkg::CMD_QUERY, 32'sd206554, 32'sd100000, 32'sd50000);
        send_item(vog_pkg::CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'sd0);
        send_item(vog_pkg::CMD_MARK, 32'sd6553, 32'sd6554, 32'sd6553);
        send_item(vog_pkg::CMD_QUERY, 32'sd0, 32'sd6554, 32'sd0);
        send_item(vog_pkg::CMD_MARK, -32'sd1, -32'sd1, -32'sd1);
        send_item(vog_pkg::CMD_QUERY, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        send_item(vog_pkg::CMD_QUERY, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    endtask

    // Register extremes: zero, one LSB and all-ones voxels per metre, the widest
    // box, an empty box with the origin above the limit, and a box that
    // reaches far past the grid so that marks beyond it must be dropped.
    task automatic test_extreme_settings();
        apply_map_settings(0, 0, 0, Q_MAX_L, Q_MAX_L, Q_MAX_L, 32'd0);
        repeat (12) send_random_item();
        apply_map_settings(Q_MIN_L, Q_MIN_L, Q_MIN_L, Q_MAX_L, Q_MAX_L, Q_MAX_L, 32'd1);
        repeat (12) send_random_item();
        apply_map_settings(Q_MIN_L, Q_MIN_L, Q_MIN_L, Q_MAX_L, Q_MAX_L, Q_MAX_L, 32'hffff_ffff);
        repeat (12) send_random_item();
        apply_map_settings(Q_MAX_L, Q_MAX_L, Q_MAX_L, Q_MIN_L, Q_MIN_L, Q_MIN_L,
                           vog_pkg::INV_RES_RST);
        repeat (12) send_random_item();
        apply_map_settings(0, 0, 0, 100 * ONE_M, 100 * ONE_M, 100 * ONE_M,
                           vog_pkg::INV_RES_RST);
        repeat (12) send_random_item();
    endtask

    // Six maps of random traffic under the three idling patterns. Each map
    // pauses halfway until every query has been answered.
    task automatic test_random_traffic();
        longint                      o [3];
        longint                      l [3];
        longint                      reach;
        logic [vog_pkg::COORD_W-1:0] rate;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 35;
            end
            if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase) inside
                0, 5:
                begin
                    apply_map_settings(vog_pkg::ORIGIN_RST, vog_pkg::ORIGIN_RST,
                                       vog_pkg::ORIGIN_RST, vog_pkg::LIMIT_X_RST,
                                       vog_pkg::LIMIT_Y_RST, vog_pkg::LIMIT_Z_RST,
                                       vog_pkg::INV_RES_RST);
                end
                1:
                begin
                    // Map centered on zero, so negative coordinates get marked.
                    apply_map_settings(-209715, -209715, -52429, 209715, 209715, 52429,
                                       vog_pkg::INV_RES_RST);
                end
                2:
                begin
                    // 5 cm voxels with an offset origin.
                    apply_map_settings(ONE_M, -2 * ONE_M, ONE_M / 2, ONE_M + 209715,
                                       -2 * ONE_M + 209715, ONE_M / 2 + 52429, 32'd1310720);
                end
                default:
                begin
                    // Random origin and resolution; the limit lands within a
                    // metre of the grid's far edge, on either side.
                    rate = $urandom_range(32'h0010_0000, 32'h0000_4000);
                    for (int k = 0; k < 3; k++)
                    begin
                        o[k] = longint'($urandom_range(131072000)) - 65536000;
                        reach = (longint'(grid_size(k)) <<< 32) / longint'(rate);
                        l[k] = o[k] + reach + longint'($urandom_range(2 * 65536)) - ONE_M;
                    end
                    apply_map_settings(o[0], o[1], o[2], l[0], l[1], l[2], rate);
                end
            endcase
            repeat (ITEMS_PER_MAP / 2) send_random_item();
            wait_idle();
            repeat (ITEMS_PER_MAP - ITEMS_PER_MAP / 2) send_random_item();
        end
    endtask

    // Every result transaction is checked against the oldest pending query.
    always @(posedge clk)
    begin : free_check
        free_expect_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (free_expected.size() == 0)
            begin
                flag_mismatch($sformatf("result with no query pending, is_free=%b",
                                        result_ch.is_free));
            end
            else
            begin
                want = free_expected.pop_front();
                if (result_ch.is_free !== want.is_free)
                begin
                    flag_mismatch($sformatf("query (%h, %h, %h): is_free %b, expected %b",
                                            want.where[0], want.where[1], want.where[2],
                                            result_ch.is_free, want.is_free));
                end
            end
        end
    end

    // The clearing pass after reset runs before any item is taken; this bound
    // on the whole run leaves a wide margin.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.cmd = vog_pkg::CMD_MARK;
        item_ch.coord_x_in = '0;
        item_ch.coord_y_in = '0;
        item_ch.coord_z_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = vog_pkg::REG_ORIGIN_X;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_mark_and_query_directed();
        test_extreme_settings();
        test_random_traffic();
        wait_idle();

        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

### voxel_occupancy_grid.f
sv/vog_pkg.sv
sv/vog_if.sv
sv/voxel_occupancy_grid.sv
sv/vog_checker.sv
verif/tb.sv
